[rtl/mbs_pkg.sv]
// Shared types, command codes and constants of the mash and boil sequencer.
`default_nettype none

package mbs_pkg;

  // Command codes carried in the input tuser.
  typedef enum logic [3:0] {
    FUNC_PUMP    = 4'd0,
    FUNC_HEATER  = 4'd1,
    FUNC_UP      = 4'd2,
    FUNC_DOWN    = 4'd3,
    FUNC_RESET   = 4'd4,
    FUNC_ADVANCE = 4'd5,
    FUNC_PAUSE   = 4'd6,
    FUNC_LOAD    = 4'd7,
    FUNC_START   = 4'd8,
    FUNC_TICK    = 4'd9
  } func_e;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    CFG_STEP_COUNT  = 4'd0,
    CFG_SPARGE_TEMP = 4'd1,
    CFG_BOIL_TEMP   = 4'd2,
    CFG_BOIL_TIME   = 4'd3
  } cfg_idx_e;

  localparam logic [10:0] TempMax       = 11'd1500;
  localparam logic [10:0] TempStep      = 11'd10;
  localparam logic [10:0] TempNowReset  = 11'd400;
  localparam logic [10:0] TempGoalReset = 11'd600;
  localparam logic [3:0]  CntMax        = 4'd15;

  localparam logic [3:0]  StepCountReset = 4'd1;
  localparam logic [10:0] SpargeReset    = 11'd750;
  localparam logic [10:0] BoilTempReset  = 11'd1000;
  localparam logic [15:0] BoilTimeReset  = 16'd3600;

  typedef struct packed {
    logic pump;
    logic heater;
    logic timer;
    logic held;
    logic input_wait;
    logic temp_wait;
    logic session;
  } status_t;

  typedef struct packed {
    logic start_heat;
    logic mash_start;
    logic start_sparge;
    logic sparge_done;
    logic start_boil;
    logic boil_done;
  } phase_t;

  // Write request into the mash step table.
  typedef struct packed {
    logic        en;
    logic [2:0]  idx;
    logic [10:0] temp;
    logic [15:0] dur;
  } tbl_wr_t;

  function automatic logic [10:0] clamp_temp(input logic [10:0] t);
    clamp_temp = (t > TempMax) ? TempMax : t;
  endfunction

endpackage

`default_nettype wire

[rtl/mbs_step_table.sv]
// Mash step table: per-step temperatures and hold times with stage-relative reads.
`default_nettype none

module mbs_step_table
  import mbs_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire tbl_wr_t     wr_i,
  input  wire logic [3:0]  stage_i,
  output logic      [10:0] temp_first_o,
  output logic      [15:0] time_first_o,
  output logic      [10:0] temp_stage_o,
  output logic      [15:0] time_prev_o
);

  localparam int unsigned IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned Slots = 2 ** IdxW;

  // Temperatures of steps 1 and up live one slot down, so that both stage reads
  // share the single address stage - 1.
  logic [10:0] temp_first_q;
  logic [10:0] temp_hi_q [Slots];
  logic [15:0] time_q    [Slots];

  logic [4:0]      wr_idx_w;
  logic [4:0]      wr_idx_dn;
  logic            wr_ok;
  logic [3:0]      stage_dn;
  logic [IdxW-1:0] rd_slot;

  assign wr_idx_w  = {2'b00, wr_i.idx};
  assign wr_idx_dn = wr_idx_w - 5'd1;
  assign wr_ok     = wr_i.en && (32'(wr_i.idx) < DEPTH);
  assign stage_dn  = stage_i - 4'd1;
  assign rd_slot   = stage_dn[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      time_q[wr_idx_w[IdxW-1:0]] <= wr_i.dur;
      if (wr_i.idx == 3'd0) begin
        temp_first_q <= wr_i.temp;
      end else begin
        temp_hi_q[wr_idx_dn[IdxW-1:0]] <= wr_i.temp;
      end
    end
  end

  assign temp_first_o = temp_first_q;
  assign time_first_o = time_q[0];
  assign temp_stage_o = temp_hi_q[rd_slot];
  assign time_prev_o  = time_q[rd_slot];

endmodule

`default_nettype wire

[rtl/mash_boil_sequencer_top.sv]
// Top level of the mash and boil sequencer: command decode, state update, snapshot output.
//
//  channel  | dir | beat when           | contents
//  ---------+-----+---------------------+---------------------------------------------
//  s_axis   | in  | tvalid && tready    | tuser: func; tdata: command operands
//  m_axis   | out | tvalid && tready    | tdata: state snapshot after the command
//  cfg      | in  | cfg_valid && ready  | cfg_index selects register, cfg_data value
//
//  Each command's whole state update is one combinational pass from the current state
//  registers into the next state and the snapshot register. One command is accepted per
//  cycle unless the output stalls; the snapshot register frees when its beat is taken.
//  Asynchronous active-low reset clears state, flags and counters and restores defaults;
//  the step table holds no reset and needs no clearing pass.
//  A stalled output holds its snapshot and blocks new commands; cfg_ready is always high.
`default_nettype none

module mash_boil_sequencer_top
  import mbs_pkg::*;
#(
  parameter int unsigned MAX_MASH_STEPS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [0] switch_on, [3:1] step_index, [14:4] step_temperature,
  // [30:15] step_duration, [31] zero
  input  wire logic [31:0] s_axis_tdata_i,
  // [3:0] func
  input  wire logic [3:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] pump_running, [1] heater_running, [12:2] kettle_temperature,
  // [23:13] goal_temperature, [24] timer_running, [25] timer_held,
  // [41:26] seconds_remaining, [42] awaiting_input, [43] awaiting_temperature,
  // [44] session_active, [48:45] stage_number, [52:49] substage_number, [55:53] zero
  output logic      [55:0] m_axis_tdata_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam logic [4:0] MaxSteps = 5'(MAX_MASH_STEPS);

  // configuration
  logic [3:0]  step_count_q;
  logic [10:0] sparge_temp_q;
  logic [10:0] boil_temp_q;
  logic [15:0] boil_time_q;

  // sequencer state
  status_t     st_q, st_d;
  phase_t      ph_q, ph_d;
  logic [10:0] now_q, now_d;
  logic [10:0] goal_q, goal_d;
  logic [15:0] cnt_q, cnt_d;
  logic [3:0]  stage_q, stage_d;
  logic [3:0]  sub_q, sub_d;

  logic        m_valid_q;
  logic [55:0] m_data_q;

  logic        s_fire;
  logic        cfg_fire;
  tbl_wr_t     tbl_wr;
  logic [10:0] tbl_temp_first;
  logic [15:0] tbl_time_first;
  logic [10:0] tbl_temp_stage;
  logic [15:0] tbl_time_prev;
  logic [4:0]  n_steps;
  logic [4:0]  s5;
  logic [11:0] goal_up;
  logic [11:0] now_up;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign cfg_fire        = cfg_valid_i;

  assign tbl_wr.en   = s_fire && (func_e'(s_axis_tuser_i) == FUNC_LOAD);
  assign tbl_wr.idx  = s_axis_tdata_i[3:1];
  assign tbl_wr.temp = s_axis_tdata_i[14:4];
  assign tbl_wr.dur  = s_axis_tdata_i[30:15];

  mbs_step_table #(
    .DEPTH (MAX_MASH_STEPS)
  ) u_table (
    .clk_i        (clk_i),
    .wr_i         (tbl_wr),
    .stage_i      (stage_q),
    .temp_first_o (tbl_temp_first),
    .time_first_o (tbl_time_first),
    .temp_stage_o (tbl_temp_stage),
    .time_prev_o  (tbl_time_prev)
  );

  // effective step count, pulled into 1..MAX_MASH_STEPS
  always_comb begin
    if (step_count_q == 4'd0) begin
      n_steps = 5'd1;
    end else if ({1'b0, step_count_q} > MaxSteps) begin
      n_steps = MaxSteps;
    end else begin
      n_steps = {1'b0, step_count_q};
    end
  end

  assign s5      = {1'b0, stage_q};
  assign goal_up = {1'b0, goal_q} + {1'b0, TempStep};
  assign now_up  = {1'b0, now_q} + {1'b0, TempStep};

  always_comb begin
    st_d    = st_q;
    ph_d    = ph_q;
    now_d   = now_q;
    goal_d  = goal_q;
    cnt_d   = cnt_q;
    stage_d = stage_q;
    sub_d   = sub_q;

    case (func_e'(s_axis_tuser_i))
      FUNC_PUMP: begin
        st_d.pump = s_axis_tdata_i[0];
      end
      FUNC_HEATER: begin
        st_d.heater = s_axis_tdata_i[0];
      end
      FUNC_UP: begin
        goal_d = (goal_up > {1'b0, TempMax}) ? TempMax : goal_up[10:0];
      end
      FUNC_DOWN: begin
        goal_d = (goal_q > TempStep) ? goal_q - TempStep : 11'd0;
      end
      FUNC_RESET: begin
        st_d    = '0;
        cnt_d   = '0;
        now_d   = TempNowReset;
        goal_d  = TempGoalReset;
        stage_d = '0;
        sub_d   = '0;
      end
      FUNC_ADVANCE: begin
        if (st_q.input_wait) begin
          st_d.input_wait = 1'b0;
          if (ph_q.start_heat) begin
            st_d.heater      = 1'b1;
            st_d.temp_wait   = 1'b1;
            goal_d           = clamp_temp(tbl_temp_first);
            stage_d          = 4'd1;
            ph_d.start_heat  = 1'b0;
          end else if (ph_q.mash_start) begin
            cnt_d           = tbl_time_first;
            st_d.timer      = 1'b1;
            ph_d.mash_start = 1'b0;
          end else if (ph_q.start_sparge) begin
            st_d.input_wait   = 1'b1;
            ph_d.sparge_done  = 1'b1;
            ph_d.start_sparge = 1'b0;
            if (sub_q < CntMax) sub_d = sub_q + 4'd1;
          end else if (ph_q.sparge_done) begin
            st_d.heater      = 1'b1;
            if (stage_q < CntMax) stage_d = stage_q + 4'd1;
            goal_d           = clamp_temp(boil_temp_q);
            st_d.temp_wait   = 1'b1;
            ph_d.sparge_done = 1'b0;
          end else if (ph_q.start_boil) begin
            cnt_d           = boil_time_q;
            st_d.timer      = 1'b1;
            ph_d.start_boil = 1'b0;
          end else if (ph_q.boil_done) begin
            ph_d.boil_done = 1'b0;
            st_d    = '0;
            cnt_d   = '0;
            now_d   = TempNowReset;
            goal_d  = TempGoalReset;
            stage_d = '0;
            sub_d   = '0;
          end
        end
      end
      FUNC_PAUSE: begin
        if (st_q.timer) st_d.held = !st_q.held;
      end
      FUNC_START: begin
        st_d.session    = 1'b1;
        st_d.input_wait = 1'b1;
        ph_d.start_heat = 1'b1;
        goal_d          = clamp_temp(tbl_temp_first);
      end
      FUNC_TICK: begin
        // heater model first, then the timer sees what heat-reached left
        if (st_q.heater) begin
          if (goal_q > now_q) begin
            now_d = (now_up > {1'b0, TempMax}) ? TempMax : now_up[10:0];
          end else begin
            if (st_q.temp_wait) begin
              st_d.temp_wait = 1'b0;
              if (s5 == 5'd1) begin
                sub_d           = 4'd2;
                st_d.input_wait = 1'b1;
                ph_d.mash_start = 1'b1;
              end
              if (s5 > 5'd1 && s5 <= n_steps) begin
                cnt_d      = tbl_time_prev;
                st_d.timer = 1'b1;
              end
              if (s5 == n_steps + 5'd2) begin
                sub_d           = 4'd2;
                st_d.input_wait = 1'b1;
                ph_d.start_boil = 1'b1;
                st_d.heater     = 1'b1;
              end
            end
            if (goal_q < now_q && now_q > 11'd0) now_d = now_q - 11'd1;
          end
        end
        if (st_d.timer && !st_d.held) begin
          if (cnt_d > 16'd1) begin
            cnt_d = cnt_d - 16'd1;
          end else begin
            st_d.timer = 1'b0;
            cnt_d      = '0;
            if (s5 > 5'd0 && s5 < n_steps) begin
              goal_d         = clamp_temp(tbl_temp_stage);
              st_d.temp_wait = 1'b1;
              st_d.heater    = 1'b1;
              if (stage_q < CntMax) stage_d = stage_q + 4'd1;
            end
            if (s5 == n_steps) begin
              goal_d            = clamp_temp(sparge_temp_q);
              st_d.input_wait   = 1'b1;
              st_d.heater       = 1'b1;
              if (stage_q < CntMax) stage_d = stage_q + 4'd1;
              ph_d.start_sparge = 1'b1;
            end
            if (s5 == n_steps + 5'd2) begin
              st_d.pump       = 1'b0;
              st_d.heater     = 1'b0;
              st_d.input_wait = 1'b1;
              ph_d.boil_done  = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '0;
      ph_q    <= '0;
      now_q   <= TempNowReset;
      goal_q  <= TempGoalReset;
      cnt_q   <= '0;
      stage_q <= '0;
      sub_q   <= '0;
    end else if (s_fire) begin
      st_q    <= st_d;
      ph_q    <= ph_d;
      now_q   <= now_d;
      goal_q  <= goal_d;
      cnt_q   <= cnt_d;
      stage_q <= stage_d;
      sub_q   <= sub_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q  <= StepCountReset;
      sparge_temp_q <= SpargeReset;
      boil_temp_q   <= BoilTempReset;
      boil_time_q   <= BoilTimeReset;
    end else if (cfg_fire) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STEP_COUNT:  step_count_q  <= cfg_data_i[3:0];
        CFG_SPARGE_TEMP: sparge_temp_q <= cfg_data_i[10:0];
        CFG_BOIL_TEMP:   boil_temp_q   <= cfg_data_i[10:0];
        CFG_BOIL_TIME:   boil_time_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      m_data_q <= {3'b000, sub_d, stage_d, st_d.session, st_d.temp_wait, st_d.input_wait,
                   cnt_d, st_d.held, st_d.timer, goal_d, now_d, st_d.heater, st_d.pump};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef ASSERT_OFF
  a_fire_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> m_axis_tvalid_o)
    else $error("accepted command produced no snapshot beat");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("command accepted while snapshot register is stalled");

  a_temp_wait_has_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.temp_wait |-> (stage_q != 4'd0))
    else $error("waiting for temperature outside any stage");
`endif

endmodule

`default_nettype wire
